// ===== hw/rtl/tbre_pkg.sv =====
package tbre_pkg;

	// Fixed field widths
	localparam int LEN_W       = 17;   // packet bytes plus header
	localparam int PKT_W       = 16;
	localparam int DT_W        = 24;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int RATE_W      = 48;
	localparam int OUT_RATE_W  = 32;
	localparam int TOK_W       = 16;
	localparam int REFILL_W    = 50;   // refill saturates here, far above any decision point
	localparam int DEFICIT_W   = 18;
	localparam int EXCESS_W    = 49;
	localparam int REM_W       = 20;

	localparam int RATE_FRAC_BITS_DEF = 16;
	localparam int QUEUE_DEPTH        = 2;

	localparam logic [LEN_W-1:0]  HEADER_BYTES = 17'd22;
	localparam logic [REM_W:0]    DIVISOR      = 21'd1000000;   // microseconds per second
	localparam logic [63:0]       RATE_MAX     = 64'h0000_FFFF_FFFF_FFFF;
	localparam logic [63:0]       RATE_LIMIT   = 64'h0001_0000_0000_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INV_SHORT = 2'd0,
		REG_INV_LONG  = 2'd1,
		REG_TARGET    = 2'd2,
		REG_EXTRA     = 2'd3
	} tbre_reg_t;

	typedef enum logic [1:0] {
		KIND_KEEP    = 2'd0,
		KIND_DEFICIT = 2'd1,
		KIND_ABOVE   = 2'd2
	} tbre_kind_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_DIV,
		ST_LEVEL,
		ST_PROD,
		ST_SCALE,
		ST_UPDATE,
		ST_DONE
	} tbre_eng_state_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		logic [DT_W-1:0]  dt;
	} tbre_item_t;

	typedef struct packed {
		logic start;
		logic ack;
	} tbre_ctl_t;

	typedef struct packed {
		logic idle;
		logic done;
	} tbre_sts_t;

endpackage

// ===== hw/rtl/tbre_front.sv =====
module tbre_front
	import tbre_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [PKT_W-1:0]     packet_bytes,
	input  logic [DT_W-1:0]      elapsed_us,
	output logic                 item_valid,
	input  logic                 item_ready,
	output tbre_item_t           item
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	tbre_item_t            queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic                  push;
	logic                  pop;
	tbre_item_t            new_item;

	assign in_ready   = (count_q != CNT_W'(QUEUE_DEPTH));
	assign item_valid = (count_q != '0);
	assign push       = in_valid && in_ready;
	assign pop        = item_valid && item_ready;
	assign item       = queue_q[rd_ptr_q];

	// add the header once, at the door
	always_comb begin
		new_item.len = {1'b0, packet_bytes} + HEADER_BYTES;
		new_item.dt  = elapsed_us;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/tbre_scale.sv =====
module tbre_scale
	import tbre_pkg::*;
#(
	parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbre_ctl_t            ctl,
	output tbre_sts_t            sts,
	input  tbre_item_t           item,
	input  logic [CFG_W-1:0]     inv,
	input  logic [CFG_W-1:0]     target,
	input  logic [CFG_W-1:0]     extra,
	output logic [RATE_W-1:0]    rate,
	output logic [TOK_W-1:0]     tok
);

	localparam int SH     = RATE_FRAC_BITS - 8;
	localparam int PW     = RATE_W + DT_W;
	localparam int NW     = PW - RATE_FRAC_BITS;
	localparam int NSTEPS = (NW + 3) / 4;
	localparam int NPAD   = NSTEPS * 4;
	localparam int CNT_W  = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int HALF   = RATE_W / 2;

	tbre_eng_state_t        state_q, state_d;

	logic [RATE_W-1:0]      rate_q;
	logic [TOK_W-1:0]       tok_q;
	logic [LEN_W-1:0]       len_q;
	logic [DT_W-1:0]        dt_q;
	logic [CFG_W-1:0]       inv_q;
	logic [HALF+DT_W-1:0]   plo_q;
	logic [HALF+DT_W-1:0]   phi_q;
	logic [NPAD-1:0]        num_q;
	logic [REM_W-1:0]       rem_q;
	logic [CNT_W-1:0]       cnt_q;
	tbre_kind_t             kind_q;
	logic [DEFICIT_W-1:0]   def_q;
	logic [EXCESS_W-1:0]    exc_q;
	logic [TOK_W-1:0]       keep_q;
	logic [DEFICIT_W+CFG_W-1:0] inc_p_q;
	logic [EXCESS_W+CFG_W-1:0]  exc_p_q;
	logic [LEN_W+CFG_W-1:0]     flo_p_q;
	logic [RATE_W-1:0]      raised_q;
	logic [63:0]            dec_q;
	logic [RATE_W-1:0]      floor_q;

	logic [PW-1:0]          prod_sum;
	logic [REM_W:0]         div_r;
	logic [NPAD-1:0]        div_n;
	logic [63:0]            quot;
	logic [REFILL_W-1:0]    refill;
	logic [REFILL_W:0]      lvl_sum;
	logic [REFILL_W:0]      lvl;
	logic [REFILL_W:0]      exc_full;
	logic [63:0]            inc_sh;
	logic [63:0]            raised;
	logic [63:0]            floor_sh;
	logic                   to_floor;

	assign rate = rate_q;
	assign tok  = tok_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		sts.idle = 1'b0;
		sts.done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sts.idle = 1'b1;
				if (ctl.start) begin
					state_d = ST_MUL_LO;
				end
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_SUM;
			ST_SUM:    state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(NSTEPS - 1)) begin
					state_d = ST_LEVEL;
				end
			end
			ST_LEVEL:  state_d = ST_PROD;
			ST_PROD:   state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				sts.done = 1'b1;
				if (ctl.ack) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// four quotient bits a cycle, restoring, against one million
	always_comb begin
		div_r = {1'b0, rem_q};
		div_n = num_q;
		for (int k = 0; k < 4; k++) begin
			div_r = {div_r[REM_W-1:0], div_n[NPAD-1]};
			div_n = {div_n[NPAD-2:0], 1'b0};
			if (div_r >= DIVISOR) begin
				div_r    = div_r - DIVISOR;
				div_n[0] = 1'b1;
			end
		end
	end

	always_comb begin
		prod_sum = {phi_q, {HALF{1'b0}}} + PW'(plo_q);
		quot     = 64'(num_q);
		refill   = (quot > 64'({REFILL_W{1'b1}})) ? {REFILL_W{1'b1}} : quot[REFILL_W-1:0];
		lvl_sum  = {1'b0, refill} + (REFILL_W+1)'(tok_q);
		lvl      = lvl_sum - (REFILL_W+1)'(len_q);
		exc_full = lvl - (REFILL_W+1)'(target);

		inc_sh   = 64'(inc_p_q) << SH;
		raised   = 64'(rate_q) + inc_sh;
		floor_sh = 64'(flo_p_q) << SH;

		to_floor = (dec_q > 64'(rate_q)) || ((64'(rate_q) - dec_q) < 64'(floor_q));
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (ctl.start) begin
					len_q <= item.len;
					dt_q  <= item.dt;
					inv_q <= inv;
				end
			end
			ST_MUL_LO: plo_q <= rate_q[HALF-1:0] * dt_q;
			ST_MUL_HI: phi_q <= rate_q[RATE_W-1:HALF] * dt_q;
			ST_SUM: begin
				num_q <= NPAD'(prod_sum >> RATE_FRAC_BITS);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				num_q <= div_n;
				rem_q <= div_r[REM_W-1:0];
				cnt_q <= cnt_q + 1'b1;
			end
			ST_LEVEL: begin
				keep_q <= lvl[TOK_W-1:0];
				def_q  <= DEFICIT_W'(len_q) - DEFICIT_W'(lvl_sum[LEN_W-1:0])
					+ DEFICIT_W'(extra);
				exc_q  <= (exc_full > (REFILL_W+1)'(RATE_LIMIT)) ? EXCESS_W'(RATE_LIMIT)
					: exc_full[EXCESS_W-1:0];
				if (lvl_sum < (REFILL_W+1)'(len_q)) begin
					kind_q <= KIND_DEFICIT;
				end else if (lvl > (REFILL_W+1)'(target)) begin
					kind_q <= KIND_ABOVE;
				end else begin
					kind_q <= KIND_KEEP;
				end
			end
			ST_PROD: begin
				inc_p_q <= def_q * inv_q;
				exc_p_q <= exc_q * inv_q;
				flo_p_q <= len_q * inv_q;
			end
			ST_SCALE: begin
				raised_q <= (raised > RATE_MAX) ? RATE_MAX[RATE_W-1:0] : raised[RATE_W-1:0];
				floor_q  <= (floor_sh > RATE_MAX) ? RATE_MAX[RATE_W-1:0]
					: floor_sh[RATE_W-1:0];
				dec_q    <= (exc_p_q >= (EXCESS_W+CFG_W)'(RATE_LIMIT)) ? RATE_LIMIT
					: (64'(exc_p_q[RATE_W-1:0]) << SH);
			end
			default: ;
		endcase
	end

	// bucket and rate state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= '0;
			tok_q  <= '0;
		end else if (state_q == ST_UPDATE) begin
			case (kind_q)
				KIND_DEFICIT: begin
					rate_q <= raised_q;
					tok_q  <= extra;
				end
				KIND_ABOVE: begin
					if (to_floor) begin
						rate_q <= floor_q;
						tok_q  <= '0;
					end else begin
						rate_q <= rate_q - dec_q[RATE_W-1:0];
						tok_q  <= target;
					end
				end
				default: tok_q <= keep_q;
			endcase
		end
	end

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> {1'b0, rem_q} < DIVISOR)
		else $error("divider remainder out of range");

	a_start_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> state_q == ST_IDLE)
		else $error("start while busy");

	a_deficit_refills: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE && kind_q == KIND_DEFICIT |=> tok_q == extra)
		else $error("bucket not refilled after deficit");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !ctl.ack |=> state_q == ST_DONE && $stable(rate_q))
		else $error("result dropped while output busy");

endmodule

// ===== hw/rtl/token_bucket_rate_estimator_top.sv =====
// Two-scale token-bucket rate meter. Each word on the input channel is one packet:
// its length (22 header bytes are added inside) and the microseconds since the
// previous packet. Each word yields exactly one output word with the short- and
// long-scale rate estimates in whole bytes per second (saturated at 2^32-1) and
// both bucket levels after the update. A small input queue takes words while
// the two scale engines work, and an output register holds the last result, so
// neither side waits on the other beyond the engine time. Most of the engine
// time goes to the refill division by one million, which resolves four
// quotient bits a cycle (rates carry 16 fraction bits by default). Both scales
// run side by side in their own engines. Configuration registers (index: 0
// short inverse period, 1 long inverse period, 2 bucket target, 3 beta) are
// written through the cfg channel, which is always ready; write them only
// while the block is idle.
module token_bucket_rate_estimator_top
	import tbre_pkg::*;
#(
	parameter int RATE_FRAC_BITS = RATE_FRAC_BITS_DEF
)
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [PKT_W-1:0]       packet_bytes,
	input  logic [DT_W-1:0]        elapsed_us,

	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_RATE_W-1:0]  rate_short_out,
	output logic [OUT_RATE_W-1:0]  rate_long_out,
	output logic [TOK_W-1:0]       tokens_short_out,
	output logic [TOK_W-1:0]       tokens_long_out,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data
);

	logic [CFG_W-1:0]     inv_short_q;
	logic [CFG_W-1:0]     inv_long_q;
	logic [CFG_W-1:0]     target_q;
	logic [CFG_W-1:0]     extra_q;

	logic                 item_valid;
	logic                 item_ready;
	tbre_item_t           item;

	tbre_ctl_t            ctl;
	tbre_sts_t            sts_short;
	tbre_sts_t            sts_long;
	logic [RATE_W-1:0]    rate_short;
	logic [RATE_W-1:0]    rate_long;
	logic [TOK_W-1:0]     tok_short;
	logic [TOK_W-1:0]     tok_long;

	logic [RATE_W-1:0]    whole_short;
	logic [RATE_W-1:0]    whole_long;
	logic [OUT_RATE_W-1:0] sat_short;
	logic [OUT_RATE_W-1:0] sat_long;
	logic                 capture;

	// configuration: always take the word, drop unknown indexes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_short_q <= 16'd6400;
			inv_long_q  <= 16'd512;
			target_q    <= 16'd4000;
			extra_q     <= 16'd1000;
		end else if (cfg_valid && cfg_ready) begin
			case (tbre_reg_t'(cfg_index))
				REG_INV_SHORT: inv_short_q <= cfg_data;
				REG_INV_LONG:  inv_long_q  <= cfg_data;
				REG_TARGET:    target_q    <= cfg_data;
				REG_EXTRA:     extra_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept words, add the header, queue them
	tbre_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.packet_bytes (packet_bytes),
		.elapsed_us   (elapsed_us),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item)
	);

	// back: launch both engines together when they are free; they run in lockstep
	assign ctl.start  = item_valid && sts_short.idle && sts_long.idle;
	assign item_ready = ctl.start;
	// an engine may finish only into an empty, or emptying, output register
	assign ctl.ack    = !out_valid || out_ready;
	assign capture    = sts_short.done && sts_long.done && ctl.ack;

	tbre_scale #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS)
	) u_scale_short (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts_short),
		.item   (item),
		.inv    (inv_short_q),
		.target (target_q),
		.extra  (extra_q),
		.rate   (rate_short),
		.tok    (tok_short)
	);

	tbre_scale #(
		.RATE_FRAC_BITS (RATE_FRAC_BITS)
	) u_scale_long (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sts    (sts_long),
		.item   (item),
		.inv    (inv_long_q),
		.target (target_q),
		.extra  (extra_q),
		.rate   (rate_long),
		.tok    (tok_long)
	);

	// drop the fraction and saturate to the output width
	always_comb begin
		whole_short = rate_short >> RATE_FRAC_BITS;
		whole_long  = rate_long >> RATE_FRAC_BITS;
		sat_short   = (|whole_short[RATE_W-1:OUT_RATE_W]) ? '1 : whole_short[OUT_RATE_W-1:0];
		sat_long    = (|whole_long[RATE_W-1:OUT_RATE_W]) ? '1 : whole_long[OUT_RATE_W-1:0];
	end

	// output register: hold the word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (capture) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			rate_short_out   <= sat_short;
			rate_long_out    <= sat_long;
			tokens_short_out <= tok_short;
			tokens_long_out  <= tok_long;
		end
	end

	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		sts_short.done == sts_long.done && sts_short.idle == sts_long.idle)
		else $error("scale engines out of step");

	a_capture_shows: assert property (@(posedge clk) disable iff (!arst_n)
		capture |=> out_valid && rate_short_out == $past(sat_short)
			&& tokens_long_out == $past(tok_long))
		else $error("result not presented");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !capture)
		else $error("output overwritten while held");

endmodule

// ===== tb/rate_meter_checker.sv =====
`timescale 1ns / 1ps

module rate_meter_checker
	import tbre_pkg::*;
#(
	parameter int FRAC = RATE_FRAC_BITS_DEF
)
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic [PKT_W-1:0]       packet_bytes,
	input  logic [DT_W-1:0]        elapsed_us,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [OUT_RATE_W-1:0]  rate_short_out,
	input  logic [OUT_RATE_W-1:0]  rate_long_out,
	input  logic [TOK_W-1:0]       tokens_short_out,
	input  logic [TOK_W-1:0]       tokens_long_out,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     mismatches,
	output int                     backlog
);

	localparam int          INV_SHIFT     = FRAC - 8;
	localparam logic [63:0] US_PER_SEC    = 64'd1000000;
	localparam logic [63:0] INV_SHORT_RST = 64'd6400;
	localparam logic [63:0] INV_LONG_RST  = 64'd512;
	localparam logic [63:0] TARGET_RST    = 64'd4000;
	localparam logic [63:0] EXTRA_RST     = 64'd1000;

	typedef struct packed {
		logic [63:0] rate;
		logic [63:0] tokens;
	} bucket_t;

	typedef struct packed {
		logic [OUT_RATE_W-1:0] rate_short;
		logic [OUT_RATE_W-1:0] rate_long;
		logic [TOK_W-1:0]      tokens_short;
		logic [TOK_W-1:0]      tokens_long;
	} reading_t;

	logic [63:0] inv_short, inv_long, target, extra;
	bucket_t     short_bucket, long_bucket;
	reading_t    expected_readings [$];

	// One scale: refill at the current estimate, take the packet out, then adjust.
	function automatic bucket_t bucket_update(bucket_t b, logic [63:0] inv, logic [63:0] len,
						  logic [63:0] us);
		logic [63:0] refill, avail, excess, dec, floor_rate, raised;
		refill = ((b.rate >> FRAC) * us + (((b.rate & ((64'd1 << FRAC) - 1)) * us) >> FRAC))
			 / US_PER_SEC;
		avail = b.tokens + refill;
		if (avail < len) begin
			raised = b.rate + (((len - avail + extra) * inv) << INV_SHIFT);
			b.rate = (raised > RATE_MAX) ? RATE_MAX : raised;
			b.tokens = extra;
		end else if (avail - len > target) begin
			excess = (avail - len - target) * inv;
			dec = (excess >= RATE_LIMIT) ? RATE_LIMIT : (excess << INV_SHIFT);
			floor_rate = (len * inv) << INV_SHIFT;
			if (floor_rate > RATE_MAX)
				floor_rate = RATE_MAX;
			if (dec > b.rate || b.rate - dec < floor_rate) begin
				b.rate = floor_rate;
				b.tokens = 64'd0;
			end else begin
				b.rate = b.rate - dec;
				b.tokens = target;
			end
		end else begin
			b.tokens = avail - len;
		end
		return b;
	endfunction

	function automatic logic [OUT_RATE_W-1:0] whole_rate(logic [63:0] rate);
		logic [63:0] w;
		w = rate >> FRAC;
		return (w > 64'hFFFF_FFFF) ? '1 : w[OUT_RATE_W-1:0];
	endfunction

	function automatic int field_diff(string name, logic [63:0] want, logic [63:0] got);
		if (want == got)
			return 0;
		$error("%s: expected %0d, got %0d", name, want, got);
		return 1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		reading_t    got, want;
		logic [63:0] len;
		int          errs;
		errs = 0;
		if (!arst_n) begin
			inv_short    = INV_SHORT_RST;
			inv_long     = INV_LONG_RST;
			target       = TARGET_RST;
			extra        = EXTRA_RST;
			short_bucket = '0;
			long_bucket  = '0;
			expected_readings.delete();
			mismatches <= 0;
			backlog    <= 0;
		end else begin
			// retire the oldest expectation before taking the new packet
			if (out_valid && out_ready) begin
				got = '{rate_short_out, rate_long_out, tokens_short_out, tokens_long_out};
				if (expected_readings.size() == 0) begin
					$error("rate word with no packet waiting");
					errs++;
				end else begin
					want = expected_readings.pop_front();
					errs += field_diff("rate_short_out", want.rate_short, got.rate_short);
					errs += field_diff("rate_long_out", want.rate_long, got.rate_long);
					errs += field_diff("tokens_short_out", want.tokens_short,
							   got.tokens_short);
					errs += field_diff("tokens_long_out", want.tokens_long,
							   got.tokens_long);
				end
			end
			if (in_valid && in_ready) begin
				len = 64'(packet_bytes) + 64'(HEADER_BYTES);
				short_bucket = bucket_update(short_bucket, inv_short, len, 64'(elapsed_us));
				long_bucket  = bucket_update(long_bucket, inv_long, len, 64'(elapsed_us));
				want.rate_short   = whole_rate(short_bucket.rate);
				want.rate_long    = whole_rate(long_bucket.rate);
				want.tokens_short = short_bucket.tokens[TOK_W-1:0];
				want.tokens_long  = long_bucket.tokens[TOK_W-1:0];
				expected_readings.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_INV_SHORT: inv_short = 64'(cfg_data);
					REG_INV_LONG:  inv_long  = 64'(cfg_data);
					REG_TARGET:    target    = 64'(cfg_data);
					REG_EXTRA:     extra     = 64'(cfg_data);
					default: ;
				endcase
			end
			mismatches <= mismatches + errs;
			backlog    <= expected_readings.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import tbre_pkg::*;

	// Generous ceiling, far above the length of the slowest clean run.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int FLOW_ITEMS    = 80;
	localparam int FLOW_PHASES   = 5;
	localparam int SAT_ITEMS     = 300;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [PKT_W-1:0]      packet_bytes = '0;
	logic [DT_W-1:0]       elapsed_us = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [OUT_RATE_W-1:0] rate_short_out, rate_long_out;
	logic [TOK_W-1:0]      tokens_short_out, tokens_long_out;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_INV_SHORT;
	logic [CFG_W-1:0]      cfg_data = '0;

	int mismatches, backlog;
	int cycles = 0;
	int packets_sent = 0;
	int settings_used = 0;
	bit quiet = 1'b0;   // set for the closing phase: no gaps, no stalls

	token_bucket_rate_estimator_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.packet_bytes     (packet_bytes),
		.elapsed_us       (elapsed_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.rate_short_out   (rate_short_out),
		.rate_long_out    (rate_long_out),
		.tokens_short_out (tokens_short_out),
		.tokens_long_out  (tokens_long_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	rate_meter_checker meter_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.packet_bytes     (packet_bytes),
		.elapsed_us       (elapsed_us),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.rate_short_out   (rate_short_out),
		.rate_long_out    (rate_long_out),
		.tokens_short_out (tokens_short_out),
		.tokens_long_out  (tokens_long_out),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.mismatches       (mismatches),
		.backlog          (backlog)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost word ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("token_bucket_rate_estimator_top: mismatch");
			$finish;
		end
	end

	// Output side: stall in bursts of random length, otherwise hold ready for a
	// random stretch. Once the closing phase starts, hold ready high throughout.
	initial begin : result_sink
		int n;
		@(posedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 8);
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// Offer one packet word; leave valid high afterwards so that back-to-back
	// words need no second assignment in the same step. A gap, when one is
	// taken, lowers valid first and raises it again cycles later.
	task automatic send_packet(input logic [PKT_W-1:0] bytes_in, input logic [DT_W-1:0] us_in);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		packet_bytes <= bytes_in;
		elapsed_us   <= us_in;
		do @(posedge clk); while (!in_ready);
		packets_sent++;
	endtask

	// Drop valid and wait until every expected word has come back. Each packet
	// yields exactly one word, so an empty backlog means the engines are idle.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	// Write all four registers in one burst; only call while the block is idle.
	task automatic program_regs(input logic [CFG_W-1:0] inv_s, input logic [CFG_W-1:0] inv_l,
				    input logic [CFG_W-1:0] tgt, input logic [CFG_W-1:0] beta);
		tbre_reg_t        order [4];
		logic [CFG_W-1:0] vals  [4];
		order = '{REG_INV_SHORT, REG_INV_LONG, REG_TARGET, REG_EXTRA};
		vals  = '{inv_s, inv_l, tgt, beta};
		for (int i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= order[i];
			cfg_data  <= vals[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// Register value biased toward a typical band, with the extremes mixed in.
	function automatic logic [CFG_W-1:0] reg_pick(int lo, int hi);
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			2, 3:    return $urandom_range(0, 65535);
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	initial begin : stimulus
		logic [PKT_W-1:0] base_len, len;
		logic [DT_W-1:0]  base_us, us;
		int               pick;

		// Hold reset, then release at an edge.
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed edges under the reset-time registers: start from an empty
		// bucket, both field extremes, a long silence that pushes the bucket
		// over target and into the floor, and alternating bit patterns.
		send_packet(16'd0, 24'd0);
		send_packet(16'hFFFF, 24'd0);
		send_packet(16'd1500, 24'd1000);
		send_packet(16'd1500, 24'hFFFFFF);
		send_packet(16'd64, 24'd1);
		send_packet(16'hAAAA, 24'h555555);
		send_packet(16'h5555, 24'hAAAAAA);
		send_packet(16'hFFFF, 24'hFFFFFF);
		send_packet(16'd1000, 24'd100);
		send_packet(16'd1000, 24'd100);
		drain();

		// Zero inverse periods: rates must stay put while buckets still move.
		program_regs(16'd0, 16'd0, 16'd0, 16'd0);
		send_packet(16'd1500, 24'd5000);
		send_packet(16'd0, 24'hFFFFFF);
		send_packet(16'hFFFF, 24'd0);
		drain();

		// Everything at full scale.
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_packet(16'hFFFF, 24'd0);
		send_packet(16'd0, 24'hFFFFFF);
		send_packet(16'd100, 24'd10);
		send_packet(16'd1, 24'd1);
		drain();

		// Smallest step, zero target, full beta: the floor lifts a low rate.
		program_regs(16'd1, 16'd1, 16'd0, 16'hFFFF);
		send_packet(16'd1500, 24'd100);
		send_packet(16'd0, 24'hFFFFFF);
		send_packet(16'd40000, 24'd3);
		drain();

		// Drive both rates into saturation with a long run of jumbo packets,
		// then let a full-scale silence collapse them onto the floor.
		program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
		for (int i = 0; i < SAT_ITEMS; i++)
			send_packet($urandom_range(60000, 65535), 24'd0);
		send_packet(16'd0, 24'hFFFFFF);
		send_packet(16'd1500, 24'd2000);
		drain();

		// Random flows: each phase runs under its own registers (the first
		// restores the reset values) and shifts its flow every twenty packets.
		// Most packets follow the current flow with jitter; the rest are
		// bursts, long silences and full-range noise.
		for (int p = 0; p < FLOW_PHASES; p++) begin
			if (p == FLOW_PHASES - 1)
				quiet = 1'b1;
			if (p == 0)
				program_regs(16'd6400, 16'd512, 16'd4000, 16'd1000);
			else
				program_regs(reg_pick(64, 8192), reg_pick(64, 8192),
					     reg_pick(500, 8000), reg_pick(0, 3000));
			base_len = 16'd0;
			base_us  = 24'd1;
			for (int i = 0; i < FLOW_ITEMS; i++) begin
				if (i % 20 == 0) begin
					base_len = ($urandom_range(0, 3) == 0) ?
						   $urandom_range(0, 9000) : $urandom_range(40, 1500);
					base_us  = $urandom_range(1, 30000);
				end
				pick = $urandom_range(0, 19);
				len  = base_len + $urandom_range(0, base_len / 8);
				us   = base_us - base_us / 4 + $urandom_range(0, base_us / 2);
				if (pick < 2) begin
					len = $urandom_range(0, 65535);
					us  = $urandom_range(0, 24'hFFFFFF);
				end else if (pick == 2) begin
					us = $urandom_range(0, 20);
				end else if (pick == 3) begin
					us = $urandom_range(1000000, 24'hFFFFFF);
				end
				send_packet(len, us);
			end
			drain();
		end

		// Give any stray word time to show up before the verdict.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Sent %0d packets under %0d register settings, from empty and saturated",
			 packets_sent, settings_used);
		$display("buckets to random flows with bursts and silences on both scales.");
		if (mismatches == 0 && backlog == 0) begin
			$display("token_bucket_rate_estimator_top: match");
		end else begin
			$display("token_bucket_rate_estimator_top: mismatch");
		end
		$finish;
	end

endmodule
